// ===== hdl/assert_macros.svh =====
// assertion macros used by the rtl file wsg_engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assert failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error("assert failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== hdl/wsg_pkg.sv =====
// ---------------------------------------------------------------------------
// wsg_pkg
// shared types and constants of the wavetable sound generator
// ---------------------------------------------------------------------------
`default_nettype none
package wsg_pkg;
    localparam int NumChannels   = 8;
    localparam int RamBytes      = 128;
    localparam int PhaseFracBits = 17;
    localparam int QueueDepth    = 2;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_ADDR  = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    localparam logic [6:0] ChBase   = 7'h40;
    localparam logic [6:0] CountReg = 7'h7F;
    localparam logic [19:0] VolScale = 20'd576716;

    typedef struct packed {
        t_func      func;
        logic [7:0] data;
    } t_cmd;
endpackage
`default_nettype wire

// ===== hdl/wsg_front.sv =====
// ---------------------------------------------------------------------------
// wsg_front
// input side: accepts items and queues them for the engine
// ---------------------------------------------------------------------------
`default_nettype none
module wsg_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  wire wsg_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  wire            i_ready,
    output wsg_pkg::t_cmd  o_cmd
);
    wsg_pkg::t_cmd r_q [wsg_pkg::QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_cmd;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ===== hdl/wsg_engine.sv =====
// ---------------------------------------------------------------------------
// wsg_engine
// back side: ram access, per-channel tick sequencer and result register
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module wsg_engine #(
    parameter int NUM_CHANNELS    = wsg_pkg::NumChannels,
    parameter int PHASE_FRAC_BITS = wsg_pkg::PhaseFracBits
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  wire wsg_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  wire            i_ready,
    output logic [7:0]     o_read_data,
    output logic [13:0]    o_mix
);
    localparam int PW = PHASE_FRAC_BITS + 8;

    typedef enum logic [3:0] {
        S_IDLE, S_CWAIT, S_CNT, S_HI, S_VOL, S_LO, S_MID, S_START, S_CALC, S_WRAP,
        S_POS, S_SAMP, S_SCALE, S_NEXT, S_RWAIT, S_OUT
    } t_state;

    t_state r_state;
    logic [7:0]  r_ram [wsg_pkg::RamBytes];
    logic [6:0]  r_ptr;
    logic        r_inc;
    logic [PW-1:0] r_phase [8];
    logic [6:0]  r_cd [8];
    logic [10:0] r_lvl [8];

    logic [6:0]  r_raddr;
    logic [7:0]  r_rdata;
    logic        r_we;
    logic [6:0]  r_waddr;
    logic [7:0]  r_wdata;
    logic        r_clr;
    logic [6:0]  r_caddr;

    logic [2:0]  r_code, r_ch;
    logic [3:0]  r_n;
    logic [7:0]  r_hi, r_lo, r_mid;
    logic [3:0]  r_vol;
    logic [7:0]  r_start;
    logic [PW:0] r_sum;
    logic [8:0]  r_len;
    logic [2:0]  r_k;
    logic [7:0]  r_pos;
    logic [26:0] r_prod;
    logic        r_upd;
    logic [13:0] r_acc;
    logic        r_ovalid;
    logic [7:0]  r_rd;

    logic        w_take;
    logic [3:0]  w_active;
    logic [6:0]  w_base;
    logic [3:0]  w_nib;
    logic [8:0]  w_int;
    logic [14:0] w_dsub;
    logic        w_ge;
    logic [7:0]  w_ipos;

    assign w_take   = (r_state == S_IDLE) && i_valid && !r_ovalid && !r_clr;
    assign w_active = (r_code >= 3'(NUM_CHANNELS - 1)) ? 4'(NUM_CHANNELS) : {1'b0, r_code} + 4'd1;
    assign w_base   = wsg_pkg::ChBase + {1'b0, r_ch, 3'b000};
    assign w_nib    = r_pos[0] ? r_rdata[7:4] : r_rdata[3:0];
    // restoring remainder of the integer phase by the wave length
    assign w_int    = r_sum[PW:PHASE_FRAC_BITS];
    assign w_dsub   = 15'({6'd0, r_len} << r_k);
    assign w_ge     = ({6'd0, w_int} >= w_dsub);
    assign w_ipos   = r_sum[PW-1:PHASE_FRAC_BITS] + r_start;

    assign o_ready     = (r_state == S_IDLE) && !r_ovalid && !r_clr;
    assign o_valid     = r_ovalid;
    assign o_read_data = r_rd;
    assign o_mix       = r_acc;

    // ram with one write and one registered read port, zeroed after reset
    always_ff @(posedge i_clk) begin
        if (r_clr) r_ram[r_caddr] <= 8'h00;
        else if (r_we) r_ram[r_waddr] <= r_wdata;
        r_rdata <= r_ram[r_raddr];
    end

    // ram clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= 1'b1; r_caddr <= '0;
        end else if (r_clr) begin
            r_caddr <= r_caddr + 7'd1;
            if (r_caddr == 7'h7F) r_clr <= 1'b0;
        end
    end

    // data write strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_we <= 1'b0;
        else r_we <= w_take && (i_cmd.func == wsg_pkg::FUNC_WRITE);
    end

    // control sequencer and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovalid <= 1'b0; r_ptr <= '0; r_inc <= 1'b0;
            for (int k = 0; k < 8; k++) begin
                r_phase[k] <= '0; r_cd[k] <= '0; r_lvl[k] <= '0;
            end
            r_raddr <= '0;
            r_upd <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (w_take) begin
                    r_rd <= '0; r_acc <= '0;
                    case (i_cmd.func)
                        wsg_pkg::FUNC_TICK: begin
                            r_raddr <= wsg_pkg::CountReg; r_state <= S_CWAIT;
                        end
                        wsg_pkg::FUNC_WRITE: begin
                            r_waddr <= r_ptr; r_wdata <= i_cmd.data;
                            r_ptr <= r_ptr + {6'd0, r_inc}; r_ovalid <= 1'b1;
                        end
                        wsg_pkg::FUNC_ADDR: begin
                            r_ptr <= i_cmd.data[6:0]; r_inc <= i_cmd.data[7];
                            r_ovalid <= 1'b1;
                        end
                        default: begin
                            r_raddr <= r_ptr; r_ptr <= r_ptr + {6'd0, r_inc};
                            r_state <= S_RWAIT;
                        end
                    endcase
                end
                S_RWAIT: r_state <= S_OUT;
                S_OUT: begin r_rd <= r_rdata; r_ovalid <= 1'b1; r_state <= S_IDLE; end
                S_CWAIT: r_state <= S_CNT;
                S_CNT: begin
                    r_code <= r_rdata[6:4]; r_ch <= 3'd7; r_n <= 4'd0;
                    r_raddr <= wsg_pkg::ChBase + 7'd60; r_state <= S_HI;
                end
                S_HI: begin
                    if (r_n >= w_active) begin
                        r_ovalid <= 1'b1; r_state <= S_IDLE;
                    end else begin
                        r_raddr <= w_base + 7'd7; r_state <= S_VOL;
                    end
                end
                S_VOL: begin
                    r_hi <= r_rdata; r_raddr <= w_base; r_state <= S_LO;
                end
                S_LO: begin
                    r_vol <= r_rdata[3:0];
                    if ((r_hi[7:5] == 3'd0) || (r_rdata[3:0] == 4'd0)) begin
                        r_state <= S_NEXT;
                    end else if (r_cd[r_ch] != 7'd0) begin
                        r_cd[r_ch] <= r_cd[r_ch] - 7'd1;
                        r_acc <= r_acc + {3'd0, r_lvl[r_ch]};
                        r_state <= S_NEXT;
                    end else begin
                        r_raddr <= w_base + 7'd2; r_state <= S_MID;
                    end
                end
                S_MID: begin r_lo <= r_rdata; r_raddr <= w_base + 7'd6; r_state <= S_START; end
                S_START: begin r_mid <= r_rdata; r_state <= S_CALC; end
                S_CALC: begin
                    r_start <= r_rdata;
                    r_sum <= {1'b0, r_phase[r_ch]} +
                        (PW+1)'({r_hi[1:0], r_mid, r_lo});
                    r_len <= 9'd256 - {1'b0, r_hi & 8'hFC};
                    r_k <= 3'd6;
                    r_state <= S_WRAP;
                end
                // one remainder step per cycle, largest shifted length first
                S_WRAP: begin
                    if (w_ge) r_sum[PW:PHASE_FRAC_BITS] <= w_int - w_dsub[8:0];
                    if (r_k == 3'd0) r_state <= S_POS;
                    else r_k <= r_k - 3'd1;
                end
                S_POS: begin
                    r_phase[r_ch] <= r_sum[PW-1:0];
                    r_pos <= w_ipos;
                    r_raddr <= w_ipos[7:1];
                    r_state <= S_SAMP;
                end
                S_SAMP: begin r_raddr <= r_pos[7:1]; r_state <= S_SCALE; end
                S_SCALE: begin
                    r_prod <= 27'(w_nib * r_vol) * 27'(wsg_pkg::VolScale);
                    r_state <= S_NEXT;
                    r_cd[r_ch] <= 7'((({4'd0, r_code} + 7'd1) * 7'd15) - 7'd1);
                    r_upd <= 1'b1;
                end
                S_NEXT: begin
                    if (r_upd) begin
                        r_lvl[r_ch] <= r_prod[26:16];
                        r_acc <= r_acc + {3'd0, r_prod[26:16]};
                    end
                    r_upd <= 1'b0;
                    r_ch <= r_ch - 3'd1; r_n <= r_n + 4'd1;
                    r_raddr <= w_base - 7'd8 + 7'd4; r_state <= S_HI;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_ready |-> (r_state == S_IDLE))
    `ASSERT_IMPL(a_rd_zero_tick, i_clk, i_rst_n, (o_valid && o_mix != 14'd0) |-> (o_read_data == 8'd0))
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready), o_valid)
endmodule
`default_nettype wire

// ===== hdl/wavetable_sound_generator.sv =====
// result valid: a write or address item on leaving S_IDLE, a data read after S_OUT
// tick: S_CWAIT, S_CNT, then per channel S_HI, S_VOL, S_LO, reload steps, S_NEXT
// throughput: one item in the engine at a time, the next taken after the result leaves
// reset: synchronous active low, clears pointer, channel state and queue
// a clearing pass then zeroes all 128 wave ram bytes before the engine takes an item
// ---------------------------------------------------------------------------
// wavetable_sound_generator
// eight-channel wavetable sound generator top level
// ---------------------------------------------------------------------------
`default_nettype none
module wavetable_sound_generator #(
    parameter int NUM_CHANNELS    = wsg_pkg::NumChannels,
    parameter int PHASE_FRAC_BITS = wsg_pkg::PhaseFracBits
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // data[7:0]
    input  wire  [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata    // read_data[7:0], mix[21:8], zero[23:22]
);
    wsg_pkg::t_cmd w_in_cmd, w_q_cmd;
    logic w_q_valid, w_q_ready;
    logic [7:0] w_rd;
    logic [13:0] w_mix;

    assign w_in_cmd.func = wsg_pkg::t_func'(s_axis_tuser);
    assign w_in_cmd.data = s_axis_tdata;
    assign m_axis_tdata = {2'b00, w_mix, w_rd};

    wsg_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(w_in_cmd),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_cmd(w_q_cmd)
    );

    wsg_engine #(.NUM_CHANNELS(NUM_CHANNELS), .PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_cmd(w_q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_read_data(w_rd), .o_mix(w_mix)
    );
endmodule
`default_nettype wire
